// ===== rtl/core/obds_pkg.sv =====
// Shared types and constants for the aggregated order book depth snapshot.
// Holds the transaction payload structs, opcodes and the controller state type.
// No dependencies.
`default_nettype none
package obds_pkg;

  localparam int PRICE_W      = 10;
  localparam int PRICE_LEVELS = 2 ** PRICE_W;
  localparam int SCAN_W       = PRICE_W + 1;
  localparam int VOL_W        = 16;
  localparam int TOT_W        = 32;
  localparam int DEPTH_W      = 6;
  localparam int MAX_DEPTH    = 32;
  localparam int CNT_W        = $clog2(MAX_DEPTH + 1);
  localparam int STK_IW       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CFG_AW       = 3;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REPORT = 1'b1;
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_DEPTH_ADDR = 3'd0;

  typedef struct packed {
    logic               opcode;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
  } in_item_t;

  typedef struct packed {
    logic               out_side;
    logic [PRICE_W-1:0] out_price;
    logic [TOT_W-1:0]   total_volume;
    logic               book_empty;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TOT_W-1:0]   vol;
  } level_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_SELL_SCAN,
    ST_SELL_EMIT,
    ST_BUY_SCAN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/order_book_depth_snapshot.sv =====
// Aggregated order book: per-price sell and buy totals in two synchronous memories,
// with a report sequencer that scans them and emits the best levels of each side.
// An add keeps busy high while its updated total is written back, so adds cannot overlap.
// A report keeps busy high through the sell scan, the sell emit, the buy scan and a finish step,
// then through a clear sweep up to the larger of the two max prices.
// Reset (synchronous, rst_n low) starts a clear sweep of all 1024 prices with busy high.
`default_nettype none
module order_book_depth_snapshot import obds_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire in_item_t            in_item,
  output logic                     out_valid,
  output out_item_t                out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  state_t              state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [DEPTH_W-1:0]  depth_r;
  logic [CNT_W-1:0]    deff_r, deff_nxt;
  logic [PRICE_W-1:0]  max_sell_r, max_sell_nxt;
  logic [PRICE_W-1:0]  max_buy_r, max_buy_nxt;
  logic [SCAN_W-1:0]   scan_p_r, scan_p_nxt;
  logic [PRICE_W-1:0]  rd_p_r, rd_p_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PRICE_W-1:0]  clr_end_r, clr_end_nxt;
  out_item_t           pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;

  level_t              stack_r [MAX_DEPTH];
  logic                push;
  level_t              push_lvl;

  logic [TOT_W-1:0]    sell_mem [PRICE_LEVELS];
  logic [TOT_W-1:0]    buy_mem  [PRICE_LEVELS];
  logic [TOT_W-1:0]    sell_rd_r, buy_rd_r;
  logic [PRICE_W-1:0]  mem_rd_addr, mem_wr_addr;
  logic [TOT_W-1:0]    mem_wd;
  logic                sell_we, buy_we;

  logic                new_vld;
  out_item_t           new_res;
  logic                issue;
  logic [TOT_W:0]      add_sum;
  logic [TOT_W-1:0]    add_old;
  logic [STK_IW-1:0]   pop_idx;
  logic                cfg_wr;

  assign pready    = 1'b1;
  assign prdata    = 32'(depth_r);
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == CFG_DEPTH_ADDR[2]);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  assign add_old  = (item_r.side == SIDE_BUY) ? buy_rd_r : sell_rd_r;
  assign add_sum  = {1'b0, add_old} + (TOT_W + 1)'(item_r.volume);
  assign pop_idx  = STK_IW'(cnt_r - 1'b1);

  always_ff @(posedge clk) begin
    if (sell_we) begin
      sell_mem[mem_wr_addr] <= mem_wd;
    end
    if (buy_we) begin
      buy_mem[mem_wr_addr] <= mem_wd;
    end
    sell_rd_r <= sell_mem[mem_rd_addr];
    buy_rd_r  <= buy_mem[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[cnt_r[STK_IW-1:0]] <= push_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      depth_r    <= DEPTH_W'(1);
      deff_r     <= CNT_W'(1);
      max_sell_r <= '0;
      max_buy_r  <= '0;
      scan_p_r   <= '0;
      rd_vld_r   <= 1'b0;
      cnt_r      <= '0;
      clr_end_r  <= PRICE_W'(PRICE_LEVELS - 1);
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr) begin
        depth_r <= pwdata[DEPTH_W-1:0];
      end
      deff_r     <= deff_nxt;
      max_sell_r <= max_sell_nxt;
      max_buy_r  <= max_buy_nxt;
      scan_p_r   <= scan_p_nxt;
      rd_vld_r   <= rd_vld_nxt;
      cnt_r      <= cnt_nxt;
      clr_end_r  <= clr_end_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rd_p_r <= rd_p_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    deff_nxt     = deff_r;
    max_sell_nxt = max_sell_r;
    max_buy_nxt  = max_buy_r;
    scan_p_nxt   = scan_p_r;
    rd_p_nxt     = rd_p_r;
    rd_vld_nxt   = 1'b0;
    cnt_nxt      = cnt_r;
    clr_end_nxt  = clr_end_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = 1'b0;
    mem_rd_addr  = scan_p_r[PRICE_W-1:0];
    mem_wr_addr  = scan_p_r[PRICE_W-1:0];
    mem_wd       = '0;
    sell_we      = 1'b0;
    buy_we       = 1'b0;
    push         = 1'b0;
    push_lvl     = '{price: rd_p_r, vol: sell_rd_r};
    new_vld      = 1'b0;
    new_res      = '0;
    issue        = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        sell_we    = 1'b1;
        buy_we     = 1'b1;
        scan_p_nxt = scan_p_r + 1'b1;
        if (scan_p_r[PRICE_W-1:0] == clr_end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_item.opcode == OP_ADD) begin
            mem_rd_addr = in_item.price;
            state_nxt   = ST_ADD_WR;
          end else begin
            if (depth_r == '0) begin
              deff_nxt = CNT_W'(1);
            end else if (depth_r > DEPTH_W'(MAX_DEPTH)) begin
              deff_nxt = CNT_W'(MAX_DEPTH);
            end else begin
              deff_nxt = CNT_W'(depth_r);
            end
            scan_p_nxt = '0;
            cnt_nxt    = '0;
            state_nxt  = ST_SELL_SCAN;
          end
        end
      end
      ST_ADD_WR: begin
        mem_wr_addr = item_r.price;
        mem_wd      = add_sum[TOT_W] ? '1 : add_sum[TOT_W-1:0];
        if (item_r.side == SIDE_BUY) begin
          buy_we = 1'b1;
          if (item_r.price > max_buy_r) begin
            max_buy_nxt = item_r.price;
          end
        end else begin
          sell_we = 1'b1;
          if (item_r.price > max_sell_r) begin
            max_sell_nxt = item_r.price;
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_SELL_SCAN: begin
        issue      = (scan_p_r <= {1'b0, max_sell_r}) && (cnt_r < deff_r);
        rd_vld_nxt = issue;
        rd_p_nxt   = scan_p_r[PRICE_W-1:0];
        scan_p_nxt = scan_p_r + 1'b1;
        if (rd_vld_r && (cnt_r < deff_r) && (sell_rd_r != '0)) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = ST_SELL_EMIT;
        end
      end
      ST_SELL_EMIT: begin
        if (cnt_r != '0) begin
          new_vld = 1'b1;
          new_res = '{out_side: SIDE_SELL, out_price: stack_r[pop_idx].price,
                      total_volume: stack_r[pop_idx].vol, book_empty: 1'b0,
                      last: 1'b0};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          scan_p_nxt = {1'b0, max_buy_r};
          state_nxt  = ST_BUY_SCAN;
        end
      end
      ST_BUY_SCAN: begin
        issue      = !scan_p_r[PRICE_W] && (cnt_r < deff_r);
        rd_vld_nxt = issue;
        rd_p_nxt   = scan_p_r[PRICE_W-1:0];
        scan_p_nxt = scan_p_r - 1'b1;
        if (rd_vld_r && (cnt_r < deff_r) && (buy_rd_r != '0)) begin
          new_vld = 1'b1;
          new_res = '{out_side: SIDE_BUY, out_price: rd_p_r, total_volume: buy_rd_r,
                      book_empty: 1'b0, last: 1'b0};
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_vld_nxt = 1'b1;
        if (pend_vld_r) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
        end else begin
          out_nxt = '{out_side: SIDE_SELL, out_price: '0, total_volume: '0,
                      book_empty: 1'b1, last: 1'b1};
        end
        pend_vld_nxt = 1'b0;
        clr_end_nxt  = (max_sell_r > max_buy_r) ? max_sell_r : max_buy_r;
        max_sell_nxt = '0;
        max_buy_nxt  = '0;
        cnt_nxt      = '0;
        scan_p_nxt   = '0;
        state_nxt    = ST_CLEAR;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // A result is held back one step so that the final one of a report can be flagged.
    if (new_vld) begin
      if (pend_vld_r) begin
        out_vld_nxt = 1'b1;
        out_nxt     = pend_r;
      end
      pend_nxt     = new_res;
      pend_vld_nxt = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.book_empty |-> out_item.last)
    else $error("empty report transaction not flagged last");

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transaction without a report in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DEPTH))
    else $error("level count beyond maximum depth");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the aggregated order book depth snapshot.
// Sends order and report transactions, programs the depth register and checks every level.
// Depends on obds_pkg and order_book_depth_snapshot.
module testbench;
  import obds_pkg::*;

  localparam int SETTLE_CYCLES = 1100;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_REPORTED  = 10;
  localparam int SAT_ORDERS    = 6;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [TOT_W-1:0]   sell_book [PRICE_LEVELS];
  logic [TOT_W-1:0]   buy_book  [PRICE_LEVELS];
  logic [PRICE_W-1:0] top_sell;
  logic [PRICE_W-1:0] top_buy;
  logic [DEPTH_W-1:0] depth_cfg;
  logic [PRICE_W-1:0] hot_prices [6];
  out_item_t          expected_levels [$];

  int  mismatches   = 0;
  int  orders_sent  = 0;
  int  reports_sent = 0;
  int  levels_seen  = 0;
  bit  idling_on    = 1'b1;

  order_book_depth_snapshot dut (.*);

  always #10 clk = ~clk;

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTED) $display("%s", msg);
  endfunction

  function automatic void clear_book();
    for (int p = 0; p < PRICE_LEVELS; p++) begin
      sell_book[p] = '0;
      buy_book[p]  = '0;
    end
    top_sell = '0;
    top_buy  = '0;
  endfunction

  function automatic void apply_order(input in_item_t item);
    logic [TOT_W:0] sum;
    if (item.side == SIDE_BUY) begin
      sum = {1'b0, buy_book[item.price]} + (TOT_W + 1)'(item.volume);
      buy_book[item.price] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
      if (item.price > top_buy) top_buy = item.price;
    end else begin
      sum = {1'b0, sell_book[item.price]} + (TOT_W + 1)'(item.volume);
      sell_book[item.price] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
      if (item.price > top_sell) top_sell = item.price;
    end
  endfunction

  // The lowest sell levels are found in ascending order but reported descending.
  function automatic void snapshot_levels();
    int        limit;
    int        cnt;
    int        picked [$];
    out_item_t run [$];
    out_item_t lvl;
    limit = (depth_cfg == 0) ? 1 : (depth_cfg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_cfg);
    for (int p = 0; p <= int'(top_sell) && picked.size() < limit; p++)
      if (sell_book[p] != '0) picked.push_back(p);
    for (int i = picked.size() - 1; i >= 0; i--) begin
      lvl              = '0;
      lvl.out_side     = SIDE_SELL;
      lvl.out_price    = PRICE_W'(picked[i]);
      lvl.total_volume = sell_book[picked[i]];
      run.push_back(lvl);
    end
    cnt = 0;
    for (int p = int'(top_buy); p >= 0 && cnt < limit; p--) begin
      if (buy_book[p] != '0) begin
        lvl              = '0;
        lvl.out_side     = SIDE_BUY;
        lvl.out_price    = PRICE_W'(p);
        lvl.total_volume = buy_book[p];
        run.push_back(lvl);
        cnt++;
      end
    end
    if (run.size() == 0) begin
      lvl            = '0;
      lvl.book_empty = 1'b1;
      lvl.last       = 1'b1;
      run.push_back(lvl);
    end else begin
      lvl      = run.pop_back();
      lvl.last = 1'b1;
      run.push_back(lvl);
    end
    foreach (run[i]) expected_levels.push_back(run[i]);
    clear_book();
  endfunction

  function automatic in_item_t order(input logic side, input int price, input int volume);
    in_item_t item;
    item.opcode = OP_ADD;
    item.side   = side;
    item.price  = PRICE_W'(price);
    item.volume = VOL_W'(volume);
    return item;
  endfunction

  function automatic in_item_t report_item();
    in_item_t item;
    item.opcode = OP_REPORT;
    item.side   = $urandom_range(0, 1) ? SIDE_BUY : SIDE_SELL;
    item.price  = PRICE_W'($urandom_range(0, PRICE_LEVELS - 1));
    item.volume = VOL_W'($urandom);
    return item;
  endfunction

  function automatic in_item_t random_order();
    in_item_t item;
    int       roll;
    item.opcode = OP_ADD;
    item.side   = $urandom_range(0, 1) ? SIDE_BUY : SIDE_SELL;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      item.price = hot_prices[$urandom_range(0, 5)];
    else if (roll < 85)
      item.price = PRICE_W'($urandom_range(0, 63));
    else
      item.price = PRICE_W'($urandom_range(0, PRICE_LEVELS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 10)
      item.volume = '0;
    else if (roll < 20)
      item.volume = '1;
    else
      item.volume = VOL_W'($urandom);
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    while (idling_on && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    if (item.opcode == OP_REPORT) begin
      snapshot_levels();
      reports_sent++;
    end else begin
      apply_order(item);
      orders_sent++;
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_DEPTH_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_depth_readback();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== {{(32 - DEPTH_W){1'b0}}, depth_cfg})
      flag_mismatch($sformatf("depth readback: expected %0d, got %0h", depth_cfg, rd));
  endtask

  task automatic set_depth(input logic [31:0] data);
    logic [31:0] rd;
    settle();
    apb_access(1'b1, data, rd);
    depth_cfg = data[DEPTH_W-1:0];
    check_depth_readback();
  endtask

  task automatic test_reset_register();
    settle();
    check_depth_readback();
  endtask

  task automatic test_price_extremes();
    send_item(order(SIDE_BUY, 0, 0) ^ '0 | report_item());
    send_item(order(SIDE_SELL, 0, 16'hFFFF));
    send_item(order(SIDE_SELL, PRICE_LEVELS - 1, 1));
    send_item(order(SIDE_BUY, 0, 1));
    send_item(order(SIDE_BUY, PRICE_LEVELS - 1, 16'hFFFF));
    send_item(order(SIDE_SELL, 700, 0));
    send_item(order(SIDE_BUY, 300, 0));
    send_item(report_item());
  endtask

  task automatic test_depth_limits();
    set_depth(MAX_DEPTH);
    send_item(order(SIDE_SELL, 5, 100));
    send_item(order(SIDE_SELL, 5, 200));
    send_item(order(SIDE_SELL, 9, 16'hFFFF));
    send_item(order(SIDE_BUY, 9, 7));
    send_item(order(SIDE_BUY, 4, 0));
    send_item(report_item());
    set_depth(0);
    send_item(order(SIDE_BUY, 2, 1));
    send_item(order(SIDE_BUY, 3, 2));
    send_item(order(SIDE_SELL, 1, 3));
    send_item(report_item());
    set_depth(32'hFFFF_FFFF);
    send_item(order(SIDE_SELL, 10, 1));
    send_item(order(SIDE_SELL, 20, 4));
    send_item(report_item());
    send_item(order(SIDE_BUY, 11, 1));
    send_item(report_item());
  endtask

  // One price collects several full-scale orders, so its total carries past sixteen bits.
  task automatic test_saturation();
    set_depth(MAX_DEPTH + 1);
    idling_on = 1'b0;
    for (int i = 0; i < SAT_ORDERS; i++) send_item(order(SIDE_BUY, 700, 16'hFFFF));
    send_item(order(SIDE_SELL, 3, 5));
    send_item(report_item());
    idling_on = 1'b1;
  endtask

  task automatic test_random_batches(input logic [31:0] data, input int quota);
    int sent;
    int adds;
    set_depth(data);
    sent = 0;
    while (sent < quota) begin
      foreach (hot_prices[i]) hot_prices[i] = PRICE_W'($urandom_range(0, 63));
      adds = $urandom_range(0, 9);
      for (int k = 0; k < adds; k++) begin
        send_item(random_order());
        sent++;
      end
      send_item(report_item());
      sent++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      levels_seen++;
      if (expected_levels.size() == 0) begin
        flag_mismatch($sformatf("unexpected level: side %0d price %0d vol %0h empty %0d last %0d",
          out_item.out_side, out_item.out_price, out_item.total_volume,
          out_item.book_empty, out_item.last));
      end else begin
        want = expected_levels.pop_front();
        if (out_item.out_side !== want.out_side || out_item.out_price !== want.out_price ||
            out_item.total_volume !== want.total_volume ||
            out_item.book_empty !== want.book_empty || out_item.last !== want.last)
          flag_mismatch($sformatf(
            "level %0d: expected side %0d price %0d vol %0h empty %0d last %0d, got %0d %0d %0h %0d %0d",
            levels_seen, want.out_side, want.out_price, want.total_volume, want.book_empty,
            want.last, out_item.out_side, out_item.out_price, out_item.total_volume,
            out_item.book_empty, out_item.last));
      end
    end
  end

  initial begin
    #(20 * 3_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    clear_book();
    depth_cfg = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_register();
    test_price_extremes();
    test_depth_limits();
    test_saturation();
    test_random_batches(1, 24);
    test_random_batches(MAX_DEPTH, 24);
    idling_on = 1'b0;
    test_random_batches(0, 24);
    idling_on = 1'b1;
    test_random_batches(32'hFFFF_FFC0 | 63, 24);
    test_random_batches(2, 24);
    test_random_batches($urandom_range(1, MAX_DEPTH), 24);
    test_random_batches($urandom_range(0, 63), 24);

    start <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && expected_levels.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_levels.size() != 0)
      flag_mismatch($sformatf("%0d expected levels never arrived", expected_levels.size()));

    $display("Sent %0d orders and %0d reports, checked %0d levels over depths 0 to 63,",
      orders_sent, reports_sent, levels_seen);
    $display("including empty books, zero volumes, price extremes and totals past 16 bits.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
